// File: design/r2fft_pkg.sv
// shared types, codes and helpers for the radix-2 fft core
package r2fft_pkg;

  // item codes
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_RUN  = 2'd1;
  localparam logic [1:0] FN_READ = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE     = 2'd1;

  // pi/2 in q31, used to build the quarter cosine table
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

  typedef struct packed {
    logic [1:0]          func;
    logic [12:0]         index;
    logic signed [15:0]  real_in;
    logic signed [15:0]  imag_in;
  } in_item_t;

  typedef struct packed {
    logic [12:0]         bin_index;
    logic signed [31:0]  real_out;
    logic signed [31:0]  imag_out;
    logic                transformed;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  // butterfly pipeline strobes
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } bf_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_BR_RD,
    ST_BR_W1,
    ST_BR_W2,
    ST_TW,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_W1,
    ST_BF_W2,
    ST_SC_RD,
    ST_SC_WR
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// File: design/r2fft_store.sv
// complex sample store: one write port, two registered read ports
module r2fft_store #(
  parameter int AW = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  r2fft_pkg::cplx_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output r2fft_pkg::cplx_t  rdata_a,
  output r2fft_pkg::cplx_t  rdata_b
);
  import r2fft_pkg::*;

  cplx_t mem [0:(1<<AW)-1];
  cplx_t rdata_a_r;
  cplx_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: design/r2fft_twiddle_rom.sv
// quarter-wave cosine table with fold logic, gives registered cos and sin
module r2fft_twiddle_rom #(
  parameter int AW = 13
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-2:0]       k,
  output logic signed [18:0]  tw_cos,
  output logic signed [18:0]  tw_sin
);
  import r2fft_pkg::*;

  localparam int RA = AW - 1;
  localparam int Q  = (1 << AW) / 4;
  localparam int H  = (1 << AW) / 2;

  typedef logic [17:0] rom_t [0:Q];

  // integer taylor series of cos in q31, rounded to q1.17
  function automatic rom_t rom_build();
    rom_t               tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    for (int kk = 0; kk <= Q; kk++) begin
      x   = (64'(kk) * HALF_PI_Q31 + 64'(Q / 2)) / 64'(Q);
      x2  = (x * x) >> 31;
      t   = 64'd1 << 31;
      sum = 64'sd1 <<< 31;
      for (int n = 1; n <= 12; n++) begin
        t = ((t * x2) >> 31) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[kk] = 18'((sum + 64'sd8192) >>> 14);
    end
    tab[0] = 18'd131072;
    tab[Q] = 18'd0;
    return tab;
  endfunction

  localparam rom_t ROM = rom_build();

  logic          second_half;
  logic [RA-1:0] addr_c;
  logic [RA-1:0] addr_s;
  logic [17:0]   cos_mag_r;
  logic [17:0]   sin_mag_r;
  logic          neg_r;

  always_comb begin
    second_half = ({1'b0, k} > AW'(Q));
    if (second_half) begin
      addr_c = RA'(AW'(H) - {1'b0, k});
      addr_s = RA'({1'b0, k} - AW'(Q));
    end else begin
      addr_c = k;
      addr_s = RA'(AW'(Q) - {1'b0, k});
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_mag_r <= ROM[addr_c];
      sin_mag_r <= ROM[addr_s];
      neg_r     <= second_half;
    end
  end

  assign tw_cos = neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
  assign tw_sin = $signed({1'b0, sin_mag_r});

endmodule

// File: design/r2fft_butterfly.sv
// butterfly datapath: registered products, registered rounded twiddle product
module r2fft_butterfly (
  input  logic                 clk,
  input  r2fft_pkg::bf_ctrl_t  ctrl,
  input  logic                 inverse,
  input  r2fft_pkg::cplx_t     a,
  input  r2fft_pkg::cplx_t     b,
  input  logic signed [18:0]   tw_cos,
  input  logic signed [18:0]   tw_sin,
  output r2fft_pkg::cplx_t     top,
  output r2fft_pkg::cplx_t     bot
);
  import r2fft_pkg::*;

  logic signed [18:0] u2;
  logic signed [50:0] p_cr_r;
  logic signed [50:0] p_ui_r;
  logic signed [50:0] p_ci_r;
  logic signed [50:0] p_ur_r;
  logic signed [51:0] d1;
  logic signed [51:0] d2;
  logic signed [52:0] r1;
  logic signed [52:0] r2;
  logic signed [35:0] t1_r;
  logic signed [35:0] t2_r;

  assign u2 = inverse ? tw_sin : -tw_sin;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_cr_r <= tw_cos * b.re;
      p_ui_r <= u2 * b.im;
      p_ci_r <= tw_cos * b.im;
      p_ur_r <= u2 * b.re;
    end
  end

  // round half up at bit 17
  always_comb begin
    d1 = 52'(p_cr_r) - 52'(p_ui_r);
    d2 = 52'(p_ci_r) + 52'(p_ur_r);
    r1 = 53'(d1) + 53'sd65536;
    r2 = 53'(d2) + 53'sd65536;
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      t1_r <= 36'(r1 >>> 17);
      t2_r <= 36'(r2 >>> 17);
    end
  end

  assign top.re = sat32(37'(a.re) + 37'(t1_r));
  assign top.im = sat32(37'(a.im) + 37'(t2_r));
  assign bot.re = sat32(37'(a.re) - 37'(t1_r));
  assign bot.im = sat32(37'(a.im) - 37'(t2_r));

endmodule

// File: design/radix2_complex_fft_core.sv
// top level of the in-place radix-2 fixed-point fft core
// A load transaction writes the store directly and leaves the core idle. The store of
// 2^LOG2_MAX_POINTS complex 32-bit words has registered read ports, so a read transaction
// holds the input side through its wait state, and longer while the previous result still
// waits in the output register; its result is registered there once the register is free
// and waits there while further loads or runs are accepted. A run transaction holds the
// input side for its whole duration, which the single write port of the store sets: with
// n = 2^m, bit reversal reads each index and writes each swapped pair back with two writes,
// the butterfly phase reads, multiplies, sums and writes back its (n/2)*m butterflies with
// one twiddle fetch per group (n-1 in total), and forward mode adds a 1/n scaling pass.
// Configuration writes are taken every cycle and must only come when idle.
module radix2_complex_fft_core #(
  parameter int LOG2_MAX_POINTS = 13
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  r2fft_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output r2fft_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import r2fft_pkg::*;

  localparam int AW = LOG2_MAX_POINTS;

  // control state
  state_t          state_r, state_nxt;
  logic [3:0]      log2_r;
  logic            inv_r;
  logic            done_r, done_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            rd_done_r, rd_done_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;       // bit reversal and scaling index
  logic [AW-1:0]   swap_j_r, swap_j_nxt;
  logic [4:0]      l_r, l_nxt;           // stage
  logic [AW:0]     j_r, j_nxt;           // twiddle group
  logic [AW:0]     i_r, i_nxt;           // top butterfly leg

  // derived values
  logic [4:0]      m_eff;
  logic [AW:0]     n_pts;
  logic [AW:0]     l1;
  logic [AW:0]     l2;
  logic [AW:0]     i1;
  logic [AW:0]     i_step;
  logic [AW:0]     j_inc;
  logic [AW-1:0]   in_addr;
  logic [AW-1:0]   rev;
  logic [AW:0]     k_full;

  // store interface
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  cplx_t           st_wdata;
  logic            st_re;
  logic [AW-1:0]   st_raddr_a;
  logic [AW-1:0]   st_raddr_b;
  cplx_t           st_rdata_a;
  cplx_t           st_rdata_b;

  // twiddle and butterfly
  logic                rom_en;
  logic signed [18:0]  tw_cos;
  logic signed [18:0]  tw_sin;
  bf_ctrl_t            bf_ctrl;
  cplx_t               bf_top;
  cplx_t               bf_bot;

  // scaling
  logic signed [32:0]  sc_re;
  logic signed [32:0]  sc_im;
  cplx_t               sc_val;

  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[AW-1-b] = v[b];
    end
    return r;
  endfunction

  // length in use: 0 acts as 1, oversize clamps to the store depth
  always_comb begin
    if (log2_r == 4'd0) begin
      m_eff = 5'd1;
    end else if (5'(log2_r) > 5'(LOG2_MAX_POINTS)) begin
      m_eff = 5'(LOG2_MAX_POINTS);
    end else begin
      m_eff = 5'(log2_r);
    end
  end

  assign n_pts   = (AW+1)'(1) << m_eff;
  assign l1      = (AW+1)'(1) << l_r;
  assign l2      = l1 << 1;
  assign i1      = i_r + l1;
  assign i_step  = i_r + l2;
  assign j_inc   = j_r + (AW+1)'(1);
  assign in_addr = AW'({{AW{1'b0}}, in_data.index});
  assign rev     = bit_rev(cnt_r[AW-1:0]) >> (5'(AW) - m_eff);
  // twiddle position j * (max/l2)
  assign k_full  = j_r << (5'(AW - 1) - l_r);

  // 1/n scaling with round half up
  always_comb begin
    sc_re     = (33'(st_rdata_a.re) + (33'sd1 <<< (m_eff - 5'd1))) >>> m_eff;
    sc_im     = (33'(st_rdata_a.im) + (33'sd1 <<< (m_eff - 5'd1))) >>> m_eff;
    sc_val.re = 32'(sc_re);
    sc_val.im = 32'(sc_im);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= 4'd13;
      inv_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOG2_POINTS: log2_r <= cfg_data[3:0];
        CFG_INVERSE:     inv_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_done_r  <= rd_done_nxt;
    cnt_r      <= cnt_nxt;
    swap_j_r   <= swap_j_nxt;
    l_r        <= l_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_addr_nxt   = rd_addr_r;
    rd_done_nxt   = rd_done_r;
    cnt_nxt       = cnt_r;
    swap_j_nxt    = swap_j_r;
    l_nxt         = l_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    st_we         = 1'b0;
    st_waddr      = in_addr;
    st_wdata.re   = 32'(in_data.real_in);
    st_wdata.im   = 32'(in_data.imag_in);
    st_re         = 1'b0;
    st_raddr_a    = in_addr;
    st_raddr_b    = in_addr;
    rom_en        = 1'b0;
    bf_ctrl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            FN_LOAD: begin
              st_we    = 1'b1;
              done_nxt = 1'b0;
            end
            FN_RUN: begin
              cnt_nxt   = '0;
              state_nxt = ST_BR_RD;
            end
            FN_READ: begin
              st_re       = 1'b1;
              rd_addr_nxt = in_addr;
              rd_done_nxt = done_r;
              state_nxt   = ST_RDWAIT;
            end
            default: ;
          endcase
        end
      end

      // store data arrived, park it once the output register is free
      ST_RDWAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.bin_index   = 13'({13'd0, rd_addr_r});
          out_data_nxt.real_out    = st_rdata_a.re;
          out_data_nxt.imag_out    = st_rdata_a.im;
          out_data_nxt.transformed = rd_done_r;
          state_nxt                = ST_IDLE;
        end
      end

      // bit reversal: swap each pair once, from its lower index
      ST_BR_RD: begin
        if (cnt_r == n_pts) begin
          l_nxt     = '0;
          j_nxt     = '0;
          i_nxt     = '0;
          state_nxt = ST_TW;
        end else if (cnt_r < {1'b0, rev}) begin
          st_re      = 1'b1;
          st_raddr_a = cnt_r[AW-1:0];
          st_raddr_b = rev;
          swap_j_nxt = rev;
          state_nxt  = ST_BR_W1;
        end else begin
          cnt_nxt = cnt_r + (AW+1)'(1);
        end
      end
      ST_BR_W1: begin
        st_we     = 1'b1;
        st_waddr  = cnt_r[AW-1:0];
        st_wdata  = st_rdata_b;
        state_nxt = ST_BR_W2;
      end
      ST_BR_W2: begin
        st_we     = 1'b1;
        st_waddr  = swap_j_r;
        st_wdata  = st_rdata_a;
        cnt_nxt   = cnt_r + (AW+1)'(1);
        state_nxt = ST_BR_RD;
      end

      // new twiddle group
      ST_TW: begin
        rom_en    = 1'b1;
        state_nxt = ST_BF_RD;
      end
      ST_BF_RD: begin
        st_re      = 1'b1;
        st_raddr_a = i_r[AW-1:0];
        st_raddr_b = i1[AW-1:0];
        state_nxt  = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        bf_ctrl.mul_en = 1'b1;
        state_nxt      = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        bf_ctrl.sum_en = 1'b1;
        state_nxt      = ST_BF_W1;
      end
      ST_BF_W1: begin
        st_we     = 1'b1;
        st_waddr  = i1[AW-1:0];
        st_wdata  = bf_bot;
        state_nxt = ST_BF_W2;
      end
      ST_BF_W2: begin
        st_we    = 1'b1;
        st_waddr = i_r[AW-1:0];
        st_wdata = bf_top;
        if (i_step < n_pts) begin
          i_nxt     = i_step;
          state_nxt = ST_BF_RD;
        end else if (j_inc < l1) begin
          j_nxt     = j_inc;
          i_nxt     = j_inc;
          state_nxt = ST_TW;
        end else if ((l_r + 5'd1) < m_eff) begin
          l_nxt     = l_r + 5'd1;
          j_nxt     = '0;
          i_nxt     = '0;
          state_nxt = ST_TW;
        end else if (inv_r) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SC_RD;
        end
      end

      // forward mode 1/n scaling
      ST_SC_RD: begin
        if (cnt_r == n_pts) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          st_re      = 1'b1;
          st_raddr_a = cnt_r[AW-1:0];
          state_nxt  = ST_SC_WR;
        end
      end
      ST_SC_WR: begin
        st_we     = 1'b1;
        st_waddr  = cnt_r[AW-1:0];
        st_wdata  = sc_val;
        cnt_nxt   = cnt_r + (AW+1)'(1);
        state_nxt = ST_SC_RD;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  r2fft_store #(.AW(AW)) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .re      (st_re),
    .raddr_a (st_raddr_a),
    .raddr_b (st_raddr_b),
    .rdata_a (st_rdata_a),
    .rdata_b (st_rdata_b)
  );

  r2fft_twiddle_rom #(.AW(AW)) u_rom (
    .clk    (clk),
    .rd_en  (rom_en),
    .k      (k_full[AW-2:0]),
    .tw_cos (tw_cos),
    .tw_sin (tw_sin)
  );

  r2fft_butterfly u_bf (
    .clk     (clk),
    .ctrl    (bf_ctrl),
    .inverse (inv_r),
    .a       (st_rdata_a),
    .b       (st_rdata_b),
    .tw_cos  (tw_cos),
    .tw_sin  (tw_sin),
    .top     (bf_top),
    .bot     (bf_bot)
  );

  // a pending read must not see the store change under it
  a_no_write_in_rdwait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDWAIT |-> !st_we)
    else $error("store written while read data pending");

  // results only come from a completed read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RDWAIT)
    else $error("result raised without a read");

  // the done flag is set only when a run finishes
  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> ($past(state_r) == ST_BF_W2 || $past(state_r) == ST_SC_RD))
    else $error("done flag set outside run completion");

  // each swap pair is handled from its lower index only
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BR_W1 |-> {1'b0, swap_j_r} > cnt_r)
    else $error("bit reversal swap out of order");

endmodule
